// ----- sv/pfrb_pkg.sv -----
// ----------------------------------------------------------------------------
// pfrb_pkg
// Types, constants and word-building helpers for the PLL register builder.
// ----------------------------------------------------------------------------
package pfrb_pkg;

    localparam int FREQ_W  = 16;
    localparam int RATIO_W = 14;
    localparam int WORD_W  = 32;
    localparam int ADDR_W  = 3;
    localparam int FIELD_W = 12;
    localparam int CFG_ADDR_W = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [FREQ_W-1:0] FREQ_MIN     = 16'd300;
    localparam logic [FREQ_W-1:0] FREQ_MAX     = 16'd3000;
    localparam logic [FREQ_W-1:0] FREQ_TOP_D8  = 16'd550;
    localparam logic [FREQ_W-1:0] FREQ_TOP_D4  = 16'd1100;
    localparam logic [FREQ_W-1:0] FREQ_TOP_D2  = 16'd2200;

    // output divider range
    typedef enum logic [1:0] {
        RNG_DIV8,
        RNG_DIV4,
        RNG_DIV2,
        RNG_DIV1
    } t_range;

    typedef struct packed {
        t_range               rng;
        logic [RATIO_W-1:0]   ratio;
    } t_cmd;

    typedef struct packed {
        logic                 prescaler;
        logic [WORD_W-1:0]    word_r2;
        logic [WORD_W-1:0]    word_r3;
        logic [WORD_W-1:0]    word_r5;
    } t_cfg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // configuration register indexes
    localparam logic [1:0] CFG_PRESCALER = 2'd0;
    localparam logic [1:0] CFG_WORD_R2   = 2'd1;
    localparam logic [1:0] CFG_WORD_R3   = 2'd2;
    localparam logic [1:0] CFG_WORD_R5   = 2'd3;

    localparam logic              RST_PRESCALER = 1'b1;
    localparam logic [WORD_W-1:0] RST_WORD_R2   = 32'h0102_8E42;
    localparam logic [WORD_W-1:0] RST_WORD_R3   = 32'h0000_04B3;
    localparam logic [WORD_W-1:0] RST_WORD_R5   = 32'h0058_0005;

    // synthesizer register numbers
    localparam logic [ADDR_W-1:0] REG_R0 = 3'd0;
    localparam logic [ADDR_W-1:0] REG_R1 = 3'd1;
    localparam logic [ADDR_W-1:0] REG_R2 = 3'd2;
    localparam logic [ADDR_W-1:0] REG_R3 = 3'd3;
    localparam logic [ADDR_W-1:0] REG_R4 = 3'd4;
    localparam logic [ADDR_W-1:0] REG_R5 = 3'd5;

    localparam logic [WORD_W-1:0] R4_DIV8 = 32'h00B0_403C;
    localparam logic [WORD_W-1:0] R4_DIV4 = 32'h00A0_403C;
    localparam logic [WORD_W-1:0] R4_DIV2 = 32'h0090_403C;
    localparam logic [WORD_W-1:0] R4_DIV1 = 32'h0080_403C;

    localparam logic [2:0] CTRL_R0 = 3'b000;
    localparam logic [2:0] CTRL_R1 = 3'b001;

    localparam logic [FIELD_W-1:0] MOD_SYNTH1  = 12'd2;
    localparam logic [FIELD_W-1:0] FRAC_SYNTH1 = 12'd0;

    function automatic logic [WORD_W-1:0] f_r4(input t_range rng);
        logic [WORD_W-1:0] w;
        case (rng)
            RNG_DIV8: w = R4_DIV8;
            RNG_DIV4: w = R4_DIV4;
            RNG_DIV2: w = R4_DIV2;
            RNG_DIV1: w = R4_DIV1;
            default:  w = R4_DIV1;
        endcase
        return w;
    endfunction

    function automatic logic [FIELD_W-1:0] f_mod2(input t_range rng);
        logic [FIELD_W-1:0] m;
        case (rng)
            RNG_DIV8: m = 12'd125;
            RNG_DIV4: m = 12'd125;
            RNG_DIV2: m = 12'd250;
            RNG_DIV1: m = 12'd500;
            default:  m = 12'd500;
        endcase
        return m;
    endfunction

    function automatic logic [FIELD_W-1:0] f_frac2(input t_range rng);
        logic [FIELD_W-1:0] fr;
        case (rng)
            RNG_DIV8: fr = 12'd2;
            default:  fr = 12'd1;
        endcase
        return fr;
    endfunction

    function automatic logic [WORD_W-1:0] f_r0(input logic [RATIO_W-1:0] ratio,
                                               input logic [FIELD_W-1:0] frac);
        return {1'b0, {(16-RATIO_W){1'b0}}, ratio, frac, CTRL_R0};
    endfunction

    function automatic logic [WORD_W-1:0] f_r1(input logic               prescaler,
                                               input logic [FIELD_W-1:0] modv);
        return {4'b0000, prescaler, 11'd0, 1'b1, modv, CTRL_R1};
    endfunction

endpackage

// ----- sv/pfrb_regs.sv -----
// ----------------------------------------------------------------------------
// pfrb_regs
// APB-style configuration registers: prescaler bit and fixed R2/R3/R5 words.
// ----------------------------------------------------------------------------
module pfrb_regs (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [pfrb_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [pfrb_pkg::WORD_W-1:0]          pwdata,
    output logic [pfrb_pkg::WORD_W-1:0]          prdata,
    output pfrb_pkg::t_cfg                       o_cfg
);
    import pfrb_pkg::*;

    t_cfg       r_cfg;
    t_cfg       n_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_idx)
                CFG_PRESCALER: n_cfg.prescaler = pwdata[0];
                CFG_WORD_R2:   n_cfg.word_r2   = pwdata;
                CFG_WORD_R3:   n_cfg.word_r3   = pwdata;
                CFG_WORD_R5:   n_cfg.word_r5   = pwdata;
                default:       n_cfg           = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prescaler <= RST_PRESCALER;
            r_cfg.word_r2   <= RST_WORD_R2;
            r_cfg.word_r3   <= RST_WORD_R3;
            r_cfg.word_r5   <= RST_WORD_R5;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (reg_idx)
            CFG_PRESCALER: prdata = {{(WORD_W-1){1'b0}}, r_cfg.prescaler};
            CFG_WORD_R2:   prdata = r_cfg.word_r2;
            CFG_WORD_R3:   prdata = r_cfg.word_r3;
            CFG_WORD_R5:   prdata = r_cfg.word_r5;
            default:       prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ----- sv/pfrb_front.sv -----
// ----------------------------------------------------------------------------
// pfrb_front
// Takes frequency requests, drops out-of-range ones, picks the divider range
// and forms the loop ratio freq*div*2 for the queue.
// ----------------------------------------------------------------------------
module pfrb_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [pfrb_pkg::FREQ_W-1:0]      i_freq_mhz,
    input  pfrb_pkg::t_q_status              i_q_status,
    output logic                             o_push,
    output pfrb_pkg::t_cmd                   o_cmd
);
    import pfrb_pkg::*;

    logic        r_vld;
    logic        n_vld;
    t_cmd        r_cmd;
    t_cmd        n_cmd;
    logic        accept;
    logic        in_range;
    t_range      rng;
    logic [2:0]  shamt;
    logic [15:0] freq_ext;
    logic [15:0] ratio_full;

    assign busy     = r_vld && i_q_status.full;
    assign accept   = start && !busy;
    assign o_push   = r_vld && !i_q_status.full;
    assign in_range = (i_freq_mhz >= FREQ_MIN) && (i_freq_mhz <= FREQ_MAX);

    always_comb begin
        if (i_freq_mhz <= FREQ_TOP_D8) begin
            rng   = RNG_DIV8;
            shamt = 3'd4;
        end else if (i_freq_mhz <= FREQ_TOP_D4) begin
            rng   = RNG_DIV4;
            shamt = 3'd3;
        end else if (i_freq_mhz <= FREQ_TOP_D2) begin
            rng   = RNG_DIV2;
            shamt = 3'd2;
        end else begin
            rng   = RNG_DIV1;
            shamt = 3'd1;
        end
    end

    // in-range frequencies fit 12 bits, ratio tops out at 8800
    assign freq_ext   = {4'b0000, i_freq_mhz[11:0]};
    assign ratio_full = freq_ext << shamt;

    always_comb begin
        n_vld = r_vld && !o_push;
        n_cmd = r_cmd;
        if (accept) begin
            n_vld       = in_range;
            n_cmd.rng   = rng;
            n_cmd.ratio = ratio_full[RATIO_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
    end

    assign o_cmd = r_cmd;

endmodule

// ----- sv/pfrb_queue.sv -----
// ----------------------------------------------------------------------------
// pfrb_queue
// Small first-word-fall-through queue of classified commands.
// ----------------------------------------------------------------------------
module pfrb_queue #(
    parameter int DEPTH = pfrb_pkg::QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  pfrb_pkg::t_cmd        i_data,
    input  logic                  i_pop,
    output pfrb_pkg::t_cmd        o_data,
    output pfrb_pkg::t_q_status   o_status
);
    import pfrb_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_status.full  = (r_cnt == CNT_FULL);
    assign o_status.empty = (r_cnt == '0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data = r_mem[r_rd_ptr];

endmodule

// ----- sv/pfrb_back.sv -----
// ----------------------------------------------------------------------------
// pfrb_back
// Sequencer that emits the twelve register words of one command, one a cycle:
// synthesizer 1 then 2, registers 5 down to 0.
// ----------------------------------------------------------------------------
module pfrb_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  pfrb_pkg::t_cfg                   i_cfg,
    input  pfrb_pkg::t_q_status              i_q_status,
    input  pfrb_pkg::t_cmd                   i_q_data,
    output logic                             o_pop,
    output logic                             o_strobe,
    output logic                             o_synth_select,
    output logic [pfrb_pkg::ADDR_W-1:0]      o_reg_address,
    output logic [pfrb_pkg::WORD_W-1:0]      o_reg_word,
    output logic                             o_last_word
);
    import pfrb_pkg::*;

    logic               r_active;
    logic               n_active;
    logic               r_synth;
    logic               n_synth;
    logic [ADDR_W-1:0]  r_addr;
    logic [ADDR_W-1:0]  n_addr;
    t_cmd               r_cmd;
    t_cmd               n_cmd;
    logic               last_step;
    logic [WORD_W-1:0]  word;
    logic [RATIO_W-1:0] ratio_s2;

    logic               r_strobe;
    logic               r_sel;
    logic [ADDR_W-1:0]  r_addr_o;
    logic [WORD_W-1:0]  r_word;
    logic               r_last;

    assign last_step = r_active && r_synth && (r_addr == REG_R0);
    assign o_pop     = !i_q_status.empty && (!r_active || last_step);

    always_comb begin
        n_active = r_active;
        n_synth  = r_synth;
        n_addr   = r_addr;
        n_cmd    = r_cmd;
        if (o_pop) begin
            // next command follows straight on from the last word
            n_active = 1'b1;
            n_synth  = 1'b0;
            n_addr   = REG_R5;
            n_cmd    = i_q_data;
        end else if (r_active) begin
            if (last_step) begin
                n_active = 1'b0;
            end else if (r_addr == REG_R0) begin
                n_synth = 1'b1;
                n_addr  = REG_R5;
            end else begin
                n_addr = r_addr - 1'b1;
            end
        end
    end

    // synth 2 sits one step below the integer ratio
    assign ratio_s2 = r_cmd.ratio - 1'b1;

    always_comb begin
        case (r_addr)
            REG_R5: word = i_cfg.word_r5;
            REG_R4: word = f_r4(r_cmd.rng);
            REG_R3: word = i_cfg.word_r3;
            REG_R2: word = i_cfg.word_r2;
            REG_R1: word = f_r1(i_cfg.prescaler, r_synth ? f_mod2(r_cmd.rng) : MOD_SYNTH1);
            REG_R0: word = r_synth ? f_r0(ratio_s2, f_frac2(r_cmd.rng))
                                   : f_r0(r_cmd.ratio, FRAC_SYNTH1);
            default: word = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_synth  <= 1'b0;
            r_addr   <= REG_R5;
            r_strobe <= 1'b0;
        end else begin
            r_active <= n_active;
            r_synth  <= n_synth;
            r_addr   <= n_addr;
            r_strobe <= r_active;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_sel    <= r_synth;
        r_addr_o <= r_addr;
        r_word   <= word;
        r_last   <= last_step;
    end

    assign o_strobe       = r_strobe;
    assign o_synth_select = r_sel;
    assign o_reg_address  = r_addr_o;
    assign o_reg_word     = r_word;
    assign o_last_word    = r_last;

endmodule

// ----- sv/pll_frequency_register_builder_top.sv -----
// ----------------------------------------------------------------------------
// pll_frequency_register_builder_top
// A request passes the front register and the queue to the word sequencer,
// which puts out its twelve words, registered, on consecutive cycles; the
// last carries o_last_word. The sequencer takes a new request only at the last
// word of the one before; a 2-entry queue plus the front register absorb
// requests. Out-of-range ones are taken, give no words. Synchronous reset clears
// control state and loads the configuration defaults; the receiver cannot stall.
// ----------------------------------------------------------------------------
module pll_frequency_register_builder_top #(
    parameter int QUEUE_DEPTH = pfrb_pkg::QUEUE_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [pfrb_pkg::FREQ_W-1:0]      i_freq_mhz,
    output logic                             o_strobe,
    output logic                             o_synth_select,
    output logic [pfrb_pkg::ADDR_W-1:0]      o_reg_address,
    output logic [pfrb_pkg::WORD_W-1:0]      o_reg_word,
    output logic                             o_last_word,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [pfrb_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [pfrb_pkg::WORD_W-1:0]      pwdata,
    output logic [pfrb_pkg::WORD_W-1:0]      prdata,
    output logic                             pready
);
    import pfrb_pkg::*;

    t_cfg      cfg;
    t_q_status q_status;
    t_cmd      push_cmd;
    t_cmd      head_cmd;
    logic      push;
    logic      pop;

    assign pready = 1'b1;

    pfrb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (cfg)
    );

    pfrb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_freq_mhz (i_freq_mhz),
        .i_q_status (q_status),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    pfrb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (push_cmd),
        .i_pop    (pop),
        .o_data   (head_cmd),
        .o_status (q_status)
    );

    pfrb_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_q_status     (q_status),
        .i_q_data       (head_cmd),
        .o_pop          (pop),
        .o_strobe       (o_strobe),
        .o_synth_select (o_synth_select),
        .o_reg_address  (o_reg_address),
        .o_reg_word     (o_reg_word),
        .o_last_word    (o_last_word)
    );

endmodule
